### rtl/sljfr_pkg.sv
// Shared types and constants for the sync/length/XOR frame receiver.
// No dependencies; used by sync_length_xor_frame_receiver.
`default_nettype none

package sljfr_pkg;

    // Receiver sequencer states
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SOURCE,
        ST_FACE,
        ST_TYPE,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_DELIVER
    } state_t;

    localparam logic [7:0] START_BYTE = 8'h7E;

    // Result field widths (fixed by the interface)
    localparam int BYTE_W     = 8;
    localparam int OUT_LEN_W  = 6;
    localparam int OUT_IDX_W  = 5;
    localparam int OUT_DATA_W = 3 * BYTE_W + OUT_LEN_W + OUT_IDX_W + BYTE_W;
    localparam int TDATA_W    = 48;
    localparam int TDATA_PAD  = TDATA_W - OUT_DATA_W;

endpackage

`default_nettype wire

### rtl/sljfr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sljfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/sync_length_xor_frame_receiver.sv
// Framed byte receiver top level: hunts for a start byte, stores header and
// payload, checks an XOR checksum and replays good frames as a result run.
// Depends on sljfr_pkg and sljfr_ram.
`default_nettype none

// Takes one received byte per request on the s_ group and delivers verified
// frames on the m_ group. A frame is 0x7E, source id, source face, frame
// type, payload length (0..MAX_PAYLOAD), the payload bytes and one checksum
// byte equal to the XOR of the payload. A start byte inside a frame is plain
// data; a length above MAX_PAYLOAD drops the frame. When rx_enable is set,
// a good frame comes out as one request per payload byte (tuser=1) or a
// single header-only request (tuser=0) for an empty frame, tlast on the
// final one; bad or disabled frames vanish silently. After a good checksum
// the input stalls while the frame is read back from the payload RAM: each
// payload byte is read from the RAM, then loaded into the output register
// before the next read; downstream stalls hold it too. No clearing pass
// after reset.
module sync_length_xor_frame_receiver #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration: rx_enable
    input  wire logic        cfg_wen,
    input  wire logic        cfg_wdata,     // [0] rx_enable

    // received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte

    // delivered results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] source_id, [15:8] source_face, [23:16] frame_type,
    // [29:24] payload_length, [34:30] byte_index, [42:35] payload_byte,
    // [47:43] zero
    output logic [47:0]      m_tdata,
    output logic             m_tuser,       // [0] has_payload
    output logic             m_tlast        // last
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_LEN_B = 8'(MAX_PAYLOAD);

    sljfr_pkg::state_t state_reg, state_next;

    logic             rx_enable_reg;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       src_reg, src_next;
    logic [7:0]       face_reg, face_next;
    logic [7:0]       type_reg, type_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;     // payload position / readback index
    logic             pend_reg, pend_next;   // RAM read in flight
    logic [LEN_W-1:0] pend_idx_reg, pend_idx_next;
    logic             pend_last_reg, pend_last_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_src_reg, out_src_next;
    logic [7:0]       out_face_reg, out_face_next;
    logic [7:0]       out_type_reg, out_type_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic             out_has_reg, out_has_next;
    logic [LEN_W-1:0] out_idx_reg, out_idx_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             in_acc;
    logic             out_free;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    logic [LEN_W-1:0] len_m1;

    sljfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg != sljfr_pkg::ST_DELIVER);
    assign in_acc   = s_tvalid && s_tready;
    assign len_m1   = len_reg - LEN_W'(1);
    // slot free for a new result next cycle, nothing already heading for it
    assign out_free = !pend_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sljfr_pkg::ST_HUNT;
            rx_enable_reg <= 1'b0;
            xor_reg       <= '0;
            src_reg       <= '0;
            face_reg      <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wen)
            begin
                rx_enable_reg <= cfg_wdata;
            end
            xor_reg       <= xor_next;
            src_reg       <= src_next;
            face_reg      <= face_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        out_src_reg   <= out_src_next;
        out_face_reg  <= out_face_next;
        out_type_reg  <= out_type_next;
        out_len_reg   <= out_len_next;
        out_has_reg   <= out_has_next;
        out_idx_reg   <= out_idx_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        xor_next       = xor_reg;
        src_next       = src_reg;
        face_next      = face_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        out_src_next   = out_src_reg;
        out_face_next  = out_face_reg;
        out_type_next  = out_type_reg;
        out_len_next   = out_len_reg;
        out_has_next   = out_has_reg;
        out_idx_next   = out_idx_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        // read data lands in the cycle after the read was issued
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_src_next   = src_reg;
            out_face_next  = face_reg;
            out_type_next  = type_reg;
            out_len_next   = len_reg;
            out_has_next   = 1'b1;
            out_idx_next   = pend_idx_reg;
            out_byte_next  = ram_rdata;
            out_last_next  = pend_last_reg;
        end

        unique case (state_reg)
            sljfr_pkg::ST_HUNT:
            begin
                if (in_acc && s_tdata == sljfr_pkg::START_BYTE)
                begin
                    xor_next   = '0;
                    state_next = sljfr_pkg::ST_SOURCE;
                end
            end
            sljfr_pkg::ST_SOURCE:
            begin
                if (in_acc)
                begin
                    src_next   = s_tdata;
                    state_next = sljfr_pkg::ST_FACE;
                end
            end
            sljfr_pkg::ST_FACE:
            begin
                if (in_acc)
                begin
                    face_next  = s_tdata;
                    state_next = sljfr_pkg::ST_TYPE;
                end
            end
            sljfr_pkg::ST_TYPE:
            begin
                if (in_acc)
                begin
                    type_next  = s_tdata;
                    state_next = sljfr_pkg::ST_LENGTH;
                end
            end
            sljfr_pkg::ST_LENGTH:
            begin
                if (in_acc)
                begin
                    if (s_tdata > MAX_LEN_B)
                    begin
                        // oversize: drop, keep old length
                        state_next = sljfr_pkg::ST_HUNT;
                    end
                    else
                    begin
                        len_next   = LEN_W'(s_tdata);
                        cnt_next   = '0;
                        state_next = sljfr_pkg::ST_PAYLOAD;
                    end
                end
            end
            sljfr_pkg::ST_PAYLOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg != len_reg)
                    begin
                        ram_we   = 1'b1;
                        xor_next = xor_reg ^ s_tdata;
                        cnt_next = cnt_reg + LEN_W'(1);
                    end
                    else
                    begin
                        // checksum byte
                        cnt_next = '0;
                        if (xor_reg == s_tdata && rx_enable_reg)
                        begin
                            state_next = sljfr_pkg::ST_DELIVER;
                        end
                        else
                        begin
                            state_next = sljfr_pkg::ST_HUNT;
                        end
                    end
                end
            end
            sljfr_pkg::ST_DELIVER:
            begin
                if (out_free)
                begin
                    if (len_reg == '0)
                    begin
                        // empty frame: header-only result
                        out_valid_next = 1'b1;
                        out_src_next   = src_reg;
                        out_face_next  = face_reg;
                        out_type_next  = type_reg;
                        out_len_next   = len_reg;
                        out_has_next   = 1'b0;
                        out_idx_next   = '0;
                        out_byte_next  = '0;
                        out_last_next  = 1'b1;
                        state_next     = sljfr_pkg::ST_HUNT;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        pend_next      = 1'b1;
                        pend_idx_next  = cnt_reg;
                        pend_last_next = (cnt_reg == len_m1);
                        cnt_next       = cnt_reg + LEN_W'(1);
                        if (cnt_reg == len_m1)
                        begin
                            state_next = sljfr_pkg::ST_HUNT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = sljfr_pkg::ST_HUNT;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {
        {sljfr_pkg::TDATA_PAD{1'b0}},
        out_byte_reg,
        sljfr_pkg::OUT_IDX_W'(out_idx_reg),
        sljfr_pkg::OUT_LEN_W'(out_len_reg),
        out_type_reg,
        out_face_reg,
        out_src_reg
    };

endmodule

`default_nettype wire
